// ===== src/idv_pkg.sv =====
package idv_pkg;

	// Configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_CHAR   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_BYTES = 1'd1;

	localparam logic [6:0]  COMMENT_CHAR_RST   = 7'd39;
	localparam logic [15:0] MAX_LINE_BYTES_RST = 16'd768;

	// Line classes reported with every result
	typedef enum logic [2:0] {
		CL_NONE    = 3'd0,
		CL_COMMENT = 3'd1,
		CL_EMPTY   = 3'd2,
		CL_INVALID = 3'd3,
		CL_UEOL    = 3'd4,
		CL_TRUNC   = 3'd5,
		CL_VALID   = 3'd6
	} line_class_t;

	typedef struct packed {
		logic [6:0]  comment_char;
		logic [15:0] max_line_bytes;
	} cfg_t;

	typedef struct packed {
		logic        emit;
		line_class_t cls;
		logic [15:0] bytes;
	} line_result_t;

endpackage

// ===== src/idv_cfg_regs.sv =====
module idv_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [idv_pkg::CFG_IDX_W-1:0]    index,
	input  logic [idv_pkg::CFG_DATA_W-1:0]   data,
	output idv_pkg::cfg_t                    cfg
);

	logic [6:0]  comment_char_q;
	logic [15:0] max_line_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_char_q   <= idv_pkg::COMMENT_CHAR_RST;
			max_line_bytes_q <= idv_pkg::MAX_LINE_BYTES_RST;
		end else if (wr_en) begin
			unique case (index)
				idv_pkg::CFG_COMMENT_CHAR:   comment_char_q   <= data[6:0];
				idv_pkg::CFG_MAX_LINE_BYTES: max_line_bytes_q <= data[15:0];
			endcase
		end
	end

	assign cfg.comment_char   = comment_char_q;
	assign cfg.max_line_bytes = max_line_bytes_q;

endmodule

// ===== src/idv_parser.sv =====
module idv_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_input,
	input  idv_pkg::cfg_t         cfg,
	output idv_pkg::line_result_t result
);

	typedef enum logic [3:0] {
		PH_START = 4'd0,
		PH_ID    = 4'd1,
		PH_WS    = 4'd2,
		PH_CM    = 4'd3,
		PH_CMP   = 4'd4,
		PH_CMS   = 4'd5,
		PH_CMA   = 4'd6,
		PH_CMC   = 4'd7,
		PH_LF    = 4'd8,
		PH_TRUNC = 4'd9
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [2:0]           idx_q, idx_d, idx_inc;
	logic [15:0]          count_q, count_d;
	idv_pkg::line_class_t pend_q, pend_d;

	logic is_byte, is_nl, is_cc, is_blank, is_graph, is_conf, is_letter;
	logic is_at, is_lpar, is_rpar, is_tilde;

	// Character classes; an end mark matches none but the tilde and lookalike tests
	always_comb begin
		is_byte   = !end_of_input;
		is_nl     = is_byte && data_byte == 8'h0A;
		is_cc     = is_byte && data_byte == {1'b0, cfg.comment_char};
		is_blank  = is_byte && (data_byte == 8'h20 || data_byte == 8'h09);
		is_graph  = is_byte && data_byte > 8'h20 && data_byte <= 8'h7E;
		is_tilde  = data_byte == 8'h7E;
		is_conf   = data_byte == 8'h49 || data_byte == 8'h7C || data_byte == 8'h6F
			|| data_byte == 8'h4F || data_byte == 8'h60 || data_byte == 8'h27;
		is_letter = is_byte && ((data_byte >= 8'h41 && data_byte <= 8'h5A)
			|| (data_byte >= 8'h61 && data_byte <= 8'h7A));
		is_at     = is_byte && data_byte == 8'h40;
		is_lpar   = is_byte && data_byte == 8'h28;
		is_rpar   = is_byte && data_byte == 8'h29;
	end

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		idx_inc = idx_q + 3'd1;

		if (phase_q == PH_TRUNC || count_q >= cfg.max_line_bytes) begin
			phase_d = PH_TRUNC;
			pend_d  = idv_pkg::CL_TRUNC;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (end_of_input) begin
						pend_d = idv_pkg::CL_NONE;
					end else if (is_cc) begin
						phase_d = PH_LF;
						pend_d  = idv_pkg::CL_COMMENT;
					end else if (is_graph) begin
						if (!is_conf) begin
							phase_d = PH_ID;
							idx_d   = 3'd0;
						end else begin
							phase_d = PH_LF;
							pend_d  = idv_pkg::CL_INVALID;
						end
					end else if (!is_nl) begin
						phase_d = PH_LF;
						pend_d  = idv_pkg::CL_INVALID;
					end else begin
						pend_d = idv_pkg::CL_EMPTY;
					end
				end
				PH_ID: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (idx_q < 3'd7) begin
						if (is_graph && !is_tilde && !is_conf) begin
							idx_d = idx_inc;
							if (idx_inc >= 3'd7) phase_d = PH_WS;
						end else begin
							phase_d = PH_LF;
							pend_d  = idv_pkg::CL_INVALID;
						end
					end
				end
				PH_WS: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (is_blank) begin
						phase_d = PH_CM;
					end else begin
						phase_d = PH_LF;
						pend_d  = idv_pkg::CL_INVALID;
					end
				end
				PH_CM: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (is_cc) begin
						phase_d = PH_CMP;
					end else if (!is_blank) begin
						phase_d = PH_LF;
						pend_d  = idv_pkg::CL_INVALID;
					end
				end
				PH_CMP: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (!is_at && !is_blank) begin
						phase_d = PH_CMS;
					end else if (!is_blank) begin
						phase_d = PH_LF;
						pend_d  = idv_pkg::CL_INVALID;
					end
				end
				PH_CMS: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (is_at) begin
						phase_d = PH_CMA;
					end
				end
				PH_CMA: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (!is_lpar && !is_blank) begin
						phase_d = PH_CMC;
					end else if (!is_blank) begin
						phase_d = PH_LF;
						pend_d  = idv_pkg::CL_INVALID;
					end
				end
				PH_CMC: begin
					if (is_nl) begin
						pend_d = idv_pkg::CL_UEOL;
					end else if (is_lpar) begin
						idx_d = 3'd1;
					end else if (idx_q < 3'd4) begin
						if (idx_q < 3'd3 && is_letter) begin
							idx_d = idx_inc;
						end else if (idx_q == 3'd3 && is_rpar) begin
							phase_d = PH_LF;
							pend_d  = idv_pkg::CL_VALID;
						end else begin
							phase_d = PH_LF;
							pend_d  = idv_pkg::CL_INVALID;
						end
					end
				end
				default: ;
			endcase
		end

		// Saturating byte count; the end mark is not a byte
		if (is_byte && count_q != 16'hFFFF) count_d = count_q + 16'd1;
		else count_d = count_q;
	end

	assign result.emit  = is_nl || end_of_input;
	assign result.cls   = pend_d;
	assign result.bytes = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			idx_q   <= 3'd0;
			count_q <= 16'd0;
			pend_q  <= idv_pkg::CL_NONE;
		end else if (step) begin
			if (result.emit) begin
				phase_q <= PH_START;
				idx_q   <= 3'd0;
				count_q <= 16'd0;
				pend_q  <= idv_pkg::CL_NONE;
			end else begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				count_q <= count_d;
				pend_q  <= pend_d;
			end
		end
	end

endmodule

// ===== src/id_list_line_validator.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   data_byte[7:0], end_of_input
// out       output     out_valid / out_ready line_class[2:0], line_bytes[15:0]
// cfg       input      cfg_wr_en             cfg_index[0:0], cfg_data[15:0]
//
// One request per cycle sustained while out is not stalled; a result shows on out
// once its request has passed the input register and one parse step into the result
// register. The loop through the line state registers sets the rate.
// Reset clears the line state, both valid flags and restores the register defaults.
// A stall on out holds the parse stage; a request is still taken into the
// input register while a finished result waits, as long as that register is empty.
module id_list_line_validator (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_input,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     line_class,
	output logic [15:0]                    line_bytes,

	input  logic                           cfg_wr_en,
	input  logic [idv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [idv_pkg::CFG_DATA_W-1:0] cfg_data
);

	idv_pkg::cfg_t         cfg;
	idv_pkg::line_result_t result;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// Result register
	logic        out_valid_q;
	logic [2:0]  class_q;
	logic [15:0] bytes_q;

	logic advance, step;

	idv_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// The parse stage moves only when the result register can take a new result
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	idv_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.cfg          (cfg),
		.result       (result)
	);

	// Capture a new request; drop the stage once parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// Load a result when a line closes; hold it until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && result.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.emit) begin
			class_q <= result.cls;
			bytes_q <= result.bytes;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_class = class_q;
	assign line_bytes = bytes_q;

endmodule

// ===== src/idv_checker.sv =====
module idv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  line_class,
	input logic [15:0] line_bytes
);

	// A stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(line_class) && $stable(line_bytes))
		else $error("result payload changed while stalled");

	// An empty line is just its newline
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_class == idv_pkg::CL_EMPTY |-> line_bytes == 16'd1)
		else $error("empty line with wrong byte count");

	// The shortest valid line needs seventeen bytes
	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_class == idv_pkg::CL_VALID |-> line_bytes >= 16'd17)
		else $error("valid line too short");

endmodule

bind id_list_line_validator idv_checker u_idv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.line_class (line_class),
	.line_bytes (line_bytes)
);

// ===== test/id_list_line_validator_checker.sv =====
module id_list_line_validator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_input,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [2:0]                     line_class,
	input  logic [15:0]                    line_bytes,
	input  logic                           cfg_wr_en,
	input  logic [idv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [idv_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             results_owed
);

	localparam int C_TAB    = 8'h09;
	localparam int C_LF     = 8'h0A;
	localparam int C_SPACE  = 8'h20;
	localparam int C_LPAREN = 8'h28;
	localparam int C_RPAREN = 8'h29;
	localparam int C_AT     = 8'h40;
	localparam int C_TILDE  = 8'h7E;
	localparam int NO_BYTE  = -1;

	typedef enum logic [3:0] {
		SEEK_LINE,
		IN_ID,
		NEED_BLANK,
		NEED_MARK,
		NAME_HEAD,
		NAME_BODY,
		SITE_HEAD,
		SITE_CODE,
		SKIP_TO_EOL,
		OVER_LIMIT
	} scan_phase_t;

	typedef struct packed {
		idv_pkg::line_class_t cls;
		logic [15:0]          nbytes;
	} line_report_t;

	scan_phase_t          phase      = SEEK_LINE;
	logic [2:0]           id_pos     = '0;
	logic [15:0]          count      = '0;
	idv_pkg::line_class_t cls_held   = idv_pkg::CL_NONE;
	logic [6:0]           mark_char  = idv_pkg::COMMENT_CHAR_RST;
	logic [15:0]          line_limit = idv_pkg::MAX_LINE_BYTES_RST;
	line_report_t         reports_due[$];
	int                   err_seen   = 0;

	// I | o O ` and the single quote
	function automatic bit lookalike(input int c);
		return c == 8'h49 || c == 8'h7C || c == 8'h6F || c == 8'h4F ||
			c == 8'h60 || c == 8'h27;
	endfunction

	function automatic bit blank(input int c);
		return c == C_SPACE || c == C_TAB;
	endfunction

	task automatic clear_line();
		phase    = SEEK_LINE;
		id_pos   = '0;
		count    = '0;
		cls_held = idv_pkg::CL_NONE;
	endtask

	task automatic go_bad();
		phase    = SKIP_TO_EOL;
		cls_held = idv_pkg::CL_INVALID;
	endtask

	// One parse step per accepted request; an end mark acts as a non-printable byte
	task automatic advance_line(input logic [7:0] b, input logic eoi);
		int           c;
		int           mark;
		bit           nl;
		bit           letter;
		line_report_t rpt;
		c      = eoi ? NO_BYTE : int'(b);
		mark   = int'(mark_char);
		nl     = (c == C_LF);
		letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);

		if (phase == OVER_LIMIT || count >= line_limit) begin
			phase    = OVER_LIMIT;
			cls_held = idv_pkg::CL_TRUNC;
		end else begin
			case (phase)
				SEEK_LINE: begin
					if (c == NO_BYTE)
						cls_held = idv_pkg::CL_NONE;
					else if (c == mark) begin
						phase    = SKIP_TO_EOL;
						cls_held = idv_pkg::CL_COMMENT;
					end else if (c > C_SPACE && c <= C_TILDE) begin
						if (!lookalike(c)) begin
							phase  = IN_ID;
							id_pos = '0;
						end else
							go_bad();
					end else if (!nl)
						go_bad();
					else
						cls_held = idv_pkg::CL_EMPTY;
				end
				IN_ID: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (id_pos < 3'd7) begin
						if (c > C_SPACE && c < C_TILDE && !lookalike(c)) begin
							id_pos++;
							if (id_pos >= 3'd7)
								phase = NEED_BLANK;
						end else
							go_bad();
					end
				end
				NEED_BLANK: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (blank(c))
						phase = NEED_MARK;
					else
						go_bad();
				end
				NEED_MARK: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (c == mark)
						phase = NAME_HEAD;
					else if (!blank(c))
						go_bad();
				end
				NAME_HEAD: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (c != C_AT && !blank(c))
						phase = NAME_BODY;
					else if (!blank(c))
						go_bad();
				end
				NAME_BODY: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (c == C_AT)
						phase = SITE_HEAD;
				end
				SITE_HEAD: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (c != C_LPAREN && !blank(c))
						phase = SITE_CODE;
					else if (!blank(c))
						go_bad();
				end
				SITE_CODE: begin
					if (nl)
						cls_held = idv_pkg::CL_UEOL;
					else if (c == C_LPAREN)
						id_pos = 3'd1;
					else if (id_pos < 3'd4) begin
						if (id_pos < 3'd3 && letter)
							id_pos++;
						else if (id_pos == 3'd3 && c == C_RPAREN) begin
							phase    = SKIP_TO_EOL;
							cls_held = idv_pkg::CL_VALID;
						end else
							go_bad();
					end
				end
				default: ;
			endcase
		end

		if (!eoi && count != 16'hFFFF)
			count++;

		if (nl || eoi) begin
			rpt.cls    = cls_held;
			rpt.nbytes = count;
			reports_due.push_back(rpt);
			clear_line();
		end
	endtask

	task automatic check_report();
		line_report_t want;
		if (reports_due.size() == 0) begin
			err_seen++;
			if (err_seen <= 10)
				$display("unexpected result: line_class %0d line_bytes %0d",
					line_class, line_bytes);
		end else begin
			want = reports_due.pop_front();
			if (line_class !== want.cls || line_bytes !== want.nbytes) begin
				err_seen++;
				if (err_seen <= 10)
					$display("mismatch: line_class exp %0d got %0d, line_bytes exp %0d got %0d",
						want.cls, line_class, want.nbytes, line_bytes);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			mark_char  = idv_pkg::COMMENT_CHAR_RST;
			line_limit = idv_pkg::MAX_LINE_BYTES_RST;
			clear_line();
			reports_due.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					idv_pkg::CFG_COMMENT_CHAR:   mark_char  = cfg_data[6:0];
					idv_pkg::CFG_MAX_LINE_BYTES: line_limit = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				advance_line(data_byte, end_of_input);
			if (out_valid && out_ready)
				check_report();
		end
		mismatches   <= err_seen;
		results_owed <= reports_due.size();
	end

endmodule

// ===== test/id_list_line_validator_tb.sv =====
module id_list_line_validator_tb;

	// Far above the slowest legal run: ~1.6K requests under 50% gaps and stalls
	localparam int CYCLE_LIMIT = 100_000;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte    = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [2:0]  line_class;
	logic [15:0] line_bytes;
	logic        cfg_wr_en    = 1'b0;
	logic [idv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [idv_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int results_owed;
	int cycle_count        = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	// Comment symbol currently programmed; the line generator builds around it
	logic [6:0] mark_sel = idv_pkg::COMMENT_CHAR_RST;

	// Bytes of the line being built; bit 8 set means an end-of-input request
	logic [8:0] line_buf[$];

	// ID characters that the block accepts anywhere in the ID
	string id_safe = "ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijklmnpqrstuvwxyz0123456789#$%&*+-./:;<=>?!";
	string letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	string blanks  = " \t";

	always #1 clk = ~clk;

	id_list_line_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_class   (line_class),
		.line_bytes   (line_bytes),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	id_list_line_validator_checker u_line_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_class   (line_class),
		.line_bytes   (line_bytes),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	// Receiver side: stall out_ready at the phase's rate, redrawn every cycle
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Gaps drop valid
	// and scramble the payload so that nothing leaks from idle cycles.
	task automatic send_req(input logic [7:0] b, input logic eoi);
		@(negedge clk);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid     <= 1'b0;
			data_byte    <= 8'($urandom);
			end_of_input <= 1'($urandom);
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_req(s[i], 1'b0);
	endtask

	function automatic logic [7:0] pick_from(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// Drop valid, wait for every owed result, then let the pipeline run dry:
	// bytes that close no line may still sit in the two-stage path
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [idv_pkg::CFG_IDX_W-1:0] idx,
			input logic [idv_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Reprogram both registers on an idle block and set the traffic shape
	task automatic configure(input logic [6:0] mark, input logic [15:0] limit,
			input int idle_pct, input int stall_pct);
		settle();
		write_reg(idv_pkg::CFG_COMMENT_CHAR, idv_pkg::CFG_DATA_W'(mark));
		write_reg(idv_pkg::CFG_MAX_LINE_BYTES, limit);
		mark_sel           = mark;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// Build one line into line_buf. Most lines follow the full grammar with
	// random content; some get a corrupted byte or a missing tail, others are
	// comments, empty lines, raw noise or lines cut short by end of input.
	task automatic compose_line();
		int kind;
		int cut;
		line_buf.delete();
		kind = $urandom_range(99);
		if (kind < 55 || (kind >= 82 && kind < 94)) begin
			// ID: a leading tilde now and then, then seven safe characters
			line_buf.push_back({1'b0, ($urandom_range(7) == 0) ? CH_TILDE : pick_from(id_safe)});
			repeat (7) line_buf.push_back({1'b0, pick_from(id_safe)});
			repeat ($urandom_range(3, 1)) line_buf.push_back({1'b0, pick_from(blanks)});
			line_buf.push_back({1'b0, 1'b0, mark_sel});
			repeat ($urandom_range(2)) line_buf.push_back({1'b0, CH_SPACE});
			repeat ($urandom_range(6, 1)) line_buf.push_back({1'b0, pick_from(letters)});
			line_buf.push_back({1'b0, CH_AT});
			repeat ($urandom_range(1)) line_buf.push_back({1'b0, CH_SPACE});
			repeat ($urandom_range(6, 1)) line_buf.push_back({1'b0, pick_from(letters)});
			repeat ($urandom_range(1)) line_buf.push_back({1'b0, CH_SPACE});
			line_buf.push_back({1'b0, CH_LPAREN});
			repeat (2) line_buf.push_back({1'b0, pick_from(letters)});
			line_buf.push_back({1'b0, CH_RPAREN});
			repeat ($urandom_range(3)) line_buf.push_back({1'b0, pick_from(id_safe)});
			line_buf.push_back({1'b0, CH_LF});
			if (kind < 55) begin
				// maybe corrupt one byte, maybe chop the tail but keep the newline
				if ($urandom_range(99) < 35)
					line_buf[$urandom_range(line_buf.size() - 2)] = {1'b0, 8'($urandom)};
				if ($urandom_range(99) < 12) begin
					cut = $urandom_range(line_buf.size() - 2);
					while (line_buf.size() > cut + 1)
						line_buf.delete(cut);
				end
			end else begin
				// end of input somewhere inside the line
				cut = $urandom_range(line_buf.size() - 1);
				while (line_buf.size() > cut)
					void'(line_buf.pop_back());
				line_buf.push_back({1'b1, 8'($urandom)});
			end
		end else if (kind < 65) begin
			line_buf.push_back({1'b0, 1'b0, mark_sel});
			repeat ($urandom_range(10)) line_buf.push_back({1'b0, 8'($urandom_range(126, 32))});
			line_buf.push_back({1'b0, CH_LF});
		end else if (kind < 72) begin
			line_buf.push_back({1'b0, CH_LF});
		end else if (kind < 82) begin
			// raw bytes over the whole range, high half included
			repeat ($urandom_range(12, 1)) line_buf.push_back({1'b0, 8'($urandom)});
			line_buf.push_back({1'b0, CH_LF});
		end else begin
			line_buf.push_back({1'b1, 8'($urandom)});
		end
	endtask

	task automatic play_lines(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			compose_line();
			foreach (line_buf[i])
				send_req(line_buf[i][7:0], line_buf[i][8]);
			sent += line_buf.size();
		end
	endtask

	initial begin
		// Hold reset, then release it between edges
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset settings: a full valid line with a
		// tilde ID, end of input at line start, an empty line, a high byte
		// closed by end of input, a comment, a NUL byte and a lookalike
		send_text("~aZ3#$%8 'x@y(AB)\n");
		send_req(8'h00, 1'b1);
		send_text("\n");
		send_req(8'hFF, 1'b0);
		send_req(8'hA5, 1'b1);
		send_text("'\n");
		send_req(8'h00, 1'b0);
		send_text("\n");
		send_text("O\n");

		// Top comment code, widest limit: random lines at full rate
		configure(7'h7F, 16'hFFFF, 0, 0);
		play_lines(300);

		// Reset-value settings with sender gaps
		configure(idv_pkg::COMMENT_CHAR_RST, idv_pkg::MAX_LINE_BYTES_RST, 50, 0);
		play_lines(350);

		// Tight limit so lines land on both sides of it; receiver stalls
		configure(7'h23, 16'd30, 0, 50);
		play_lines(300);

		// Comment symbol equal to a blank, light gaps and stalls together
		configure(7'h20, 16'd24, 14, 14);
		play_lines(250);

		// Comment symbol equal to newline
		configure(7'h0A, idv_pkg::MAX_LINE_BYTES_RST, 0, 0);
		play_lines(150);

		// Comment code zero and a one-byte limit
		configure(7'h00, 16'd1, 50, 0);
		play_lines(100);

		// Limit of zero: every line truncated, even a bare end mark
		configure(idv_pkg::COMMENT_CHAR_RST, 16'd0, 0, 50);
		play_lines(100);

		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
